>>> design/tks_pkg.sv
// ----------------------------------------------------------------------------
// tks_pkg: shared definitions for the topological sort unit
// Sizes, input codes, sequencer states and the node store request/response.
// ----------------------------------------------------------------------------
package tks_pkg;

  // graph sizes
  localparam int MAX_NODES = 64;
  localparam int NODE_W    = 6;   // node index
  localparam int CNT_W     = 7;   // node count, 0 .. MAX_NODES
  localparam int MAX_EDGES = 256;
  localparam int EDGE_W    = 8;   // edge index
  localparam int ETOT_W    = 9;   // edge count, 0 .. MAX_EDGES
  localparam int DEG_W     = 9;   // indegree, 0 .. MAX_EDGES

  // input mode codes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_RUN  = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD_WR,
    ST_SEED,
    ST_POP,
    ST_POP_WAIT,
    ST_LIST_WAIT,
    ST_EDGE_WAIT,
    ST_DEG_WAIT,
    ST_FINISH
  } tks_state_t;

  // request to the per-node store
  typedef struct packed {
    logic              clear;
    logic              deg_we;
    logic [NODE_W-1:0] deg_waddr;
    logic [DEG_W-1:0]  deg_wdata;
    logic [NODE_W-1:0] deg_raddr;
    logic              list_we;
    logic [NODE_W-1:0] list_waddr;
    logic [EDGE_W-1:0] list_whead;
    logic [EDGE_W-1:0] list_wtail;
    logic [NODE_W-1:0] list_raddr;
  } tks_node_req_t;

  // registered read data of the per-node store
  typedef struct packed {
    logic [DEG_W-1:0]  deg;
    logic              list_vld;
    logic [EDGE_W-1:0] list_head;
    logic [EDGE_W-1:0] list_tail;
  } tks_node_rsp_t;

endpackage

>>> design/tks_node_store.sv
// ----------------------------------------------------------------------------
// tks_node_store: per-node indegree and edge list memories
// Two single-write memories with registered reads. Per-entry valid bits give
// zero indegree and an empty list for entries not written since the last clear.
// ----------------------------------------------------------------------------
module tks_node_store
  import tks_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  tks_node_req_t req,
  output tks_node_rsp_t rsp
);

  logic [DEG_W-1:0]    deg_mem  [MAX_NODES];
  logic [2*EDGE_W-1:0] list_mem [MAX_NODES];

  logic [MAX_NODES-1:0] deg_vld_r;
  logic [MAX_NODES-1:0] list_vld_r;
  logic [DEG_W-1:0]     deg_q_r;
  logic [2*EDGE_W-1:0]  list_q_r;
  logic                 deg_q_vld_r;
  logic                 list_q_vld_r;

  // memory arrays, one write and one registered read each
  always_ff @(posedge clk) begin
    if (req.deg_we) begin
      deg_mem[req.deg_waddr] <= req.deg_wdata;
    end
    if (req.list_we) begin
      list_mem[req.list_waddr] <= {req.list_whead, req.list_wtail};
    end
    deg_q_r  <= deg_mem[req.deg_raddr];
    list_q_r <= list_mem[req.list_raddr];
  end

  // valid bits, cleared by reset and at the end of a run
  always_ff @(posedge clk) begin
    if (!rst_n || req.clear) begin
      deg_vld_r    <= '0;
      list_vld_r   <= '0;
      deg_q_vld_r  <= 1'b0;
      list_q_vld_r <= 1'b0;
    end else begin
      if (req.deg_we) begin
        deg_vld_r[req.deg_waddr] <= 1'b1;
      end
      if (req.list_we) begin
        list_vld_r[req.list_waddr] <= 1'b1;
      end
      deg_q_vld_r  <= deg_vld_r[req.deg_raddr];
      list_q_vld_r <= list_vld_r[req.list_raddr];
    end
  end

  // masked read data
  always_comb begin
    rsp.deg       = deg_q_vld_r ? deg_q_r : '0;
    rsp.list_vld  = list_q_vld_r;
    rsp.list_head = list_q_r[2*EDGE_W-1:EDGE_W];
    rsp.list_tail = list_q_r[EDGE_W-1:0];
  end

  // a clear never coincides with a write
  a_clear_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    req.clear |-> !(req.deg_we || req.list_we))
    else $error("node store cleared while writing");

endmodule

>>> design/topological_sort_kahn_unit.sv
// Sequence: an edge load passes through ST_IDLE and ST_LOAD_WR (a dropped
// edge ends in ST_IDLE); a run checks each indegree in ST_SEED to fill the
// ready queue, pops each node (ST_POP, ST_POP_WAIT, ST_LIST_WAIT), walks each
// edge (ST_EDGE_WAIT, ST_DEG_WAIT) and ends in ST_FINISH with the final result.
// Flow: one transaction at a time; stalls on out_ready hold the run.
// Reset: synchronous, active low; clears counters and node valid bits at once.
// ----------------------------------------------------------------------------
// topological_sort_kahn_unit: Kahn topological sort engine
// Builds per-node edge lists from loaded edges, then emits nodes in
// topological order through a ready queue held in memory.
// ----------------------------------------------------------------------------
module topological_sort_kahn_unit
  import tks_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_wr_en,
  input  logic [CNT_W-1:0]  cfg_wr_data,
  // input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_mode,
  input  logic [NODE_W-1:0] in_edge_from,
  input  logic [NODE_W-1:0] in_edge_to,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [NODE_W-1:0] out_node,
  output logic              out_node_valid,
  output logic              out_last,
  output logic              out_cycle_found,
  output logic              out_edges_dropped
);

  localparam logic [CNT_W-1:0]  NODES_MAX = CNT_W'(MAX_NODES);
  localparam logic [ETOT_W-1:0] EDGES_MAX = ETOT_W'(MAX_EDGES);

  tks_state_t state_r, state_nxt;

  logic [CNT_W-1:0]  node_count_r;
  logic [ETOT_W-1:0] edge_total_r;
  logic [CNT_W-1:0]  rptr_r, wptr_r;
  logic [CNT_W-1:0]  emitted_r;
  logic              dropped_r;
  logic [CNT_W-1:0]  seed_idx_r;
  logic              seed_chk_vld_r;
  logic [NODE_W-1:0] seed_chk_idx_r;
  logic              pend_vld_r;
  logic [NODE_W-1:0] pend_node_r;
  logic [NODE_W-1:0] ld_src_r, ld_dst_r;
  logic [EDGE_W-1:0] edge_ptr_r, tail_r, link_r;
  logic [NODE_W-1:0] tgt_r;
  logic              last_r, tgt_ok_r;

  logic              out_valid_r;
  logic [NODE_W-1:0] out_node_r;
  logic              out_node_valid_r, out_last_r, out_cycle_found_r, out_edges_dropped_r;

  // edge and ready queue memories
  logic [NODE_W-1:0] edge_tgt_mem  [MAX_EDGES];
  logic [EDGE_W-1:0] edge_link_mem [MAX_EDGES];
  logic [NODE_W-1:0] fifo_mem      [MAX_NODES];
  logic [NODE_W-1:0] edge_tgt_q_r;
  logic [EDGE_W-1:0] edge_link_q_r;
  logic [NODE_W-1:0] fifo_q_r;

  tks_node_req_t node_req;
  tks_node_rsp_t node_rsp;

  logic [CNT_W-1:0]  n_eff;
  logic              in_fire, out_free, ld_drop, pop_more, pop_go, seed_issue, fifo_room;
  logic              tgt_we, link_we, fifo_we;
  logic [EDGE_W-1:0] link_waddr, edge_raddr, new_edge;
  logic [NODE_W-1:0] fifo_wdata;
  logic              pend_to_out, final_to_out, clear_all;

  tks_node_store u_node_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (node_req),
    .rsp   (node_rsp)
  );

  // common conditions
  assign n_eff      = (node_count_r > NODES_MAX) ? NODES_MAX : node_count_r;
  assign in_ready   = (state_r == ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;
  assign ld_drop    = (CNT_W'(in_edge_from) >= n_eff) || (CNT_W'(in_edge_to) >= n_eff) ||
                      (edge_total_r == EDGES_MAX);
  assign pop_more   = (rptr_r < wptr_r) && (emitted_r < n_eff);
  assign pop_go     = !pend_vld_r || out_free;
  assign seed_issue = (seed_idx_r < n_eff);
  assign fifo_room  = (wptr_r < NODES_MAX);
  assign new_edge   = edge_total_r[EDGE_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_mode == MODE_RUN) begin
            state_nxt = ST_SEED;
          end else if (!ld_drop) begin
            state_nxt = ST_LOAD_WR;
          end
        end
      end
      ST_LOAD_WR:   state_nxt = ST_IDLE;
      ST_SEED: begin
        if (!seed_issue && !seed_chk_vld_r) begin
          state_nxt = ST_POP;
        end
      end
      ST_POP: begin
        if (!pop_more) begin
          state_nxt = ST_FINISH;
        end else if (pop_go) begin
          state_nxt = ST_POP_WAIT;
        end
      end
      ST_POP_WAIT:  state_nxt = ST_LIST_WAIT;
      ST_LIST_WAIT: state_nxt = node_rsp.list_vld ? ST_EDGE_WAIT : ST_POP;
      ST_EDGE_WAIT: state_nxt = ST_DEG_WAIT;
      ST_DEG_WAIT:  state_nxt = last_r ? ST_POP : ST_EDGE_WAIT;
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // memory controls and result moves
  always_comb begin
    node_req            = '0;
    node_req.deg_raddr  = in_edge_to;
    node_req.list_raddr = in_edge_from;
    edge_raddr          = edge_ptr_r;
    tgt_we              = 1'b0;
    link_we             = 1'b0;
    link_waddr          = node_rsp.list_tail;
    fifo_we             = 1'b0;
    fifo_wdata          = seed_chk_idx_r;
    pend_to_out         = 1'b0;
    final_to_out        = 1'b0;
    clear_all           = 1'b0;
    unique case (state_r)
      ST_IDLE: ;
      ST_LOAD_WR: begin
        // append the edge to the source list, bump target indegree
        node_req.deg_we     = 1'b1;
        node_req.deg_waddr  = ld_dst_r;
        node_req.deg_wdata  = node_rsp.deg + DEG_W'(1);
        node_req.list_we    = 1'b1;
        node_req.list_waddr = ld_src_r;
        node_req.list_whead = node_rsp.list_vld ? node_rsp.list_head : new_edge;
        node_req.list_wtail = new_edge;
        tgt_we              = 1'b1;
        link_we             = node_rsp.list_vld;
      end
      ST_SEED: begin
        node_req.deg_raddr = seed_idx_r[NODE_W-1:0];
        if (seed_chk_vld_r && (node_rsp.deg == '0) && fifo_room) begin
          fifo_we    = 1'b1;
          fifo_wdata = seed_chk_idx_r;
        end
      end
      ST_POP: begin
        pend_to_out = pop_more && pend_vld_r && out_free;
      end
      ST_POP_WAIT: begin
        node_req.list_raddr = fifo_q_r;
      end
      ST_LIST_WAIT: begin
        edge_raddr = node_rsp.list_head;
      end
      ST_EDGE_WAIT: begin
        node_req.deg_raddr = edge_tgt_q_r;
      end
      ST_DEG_WAIT: begin
        // decrement target indegree, queue it on reaching zero
        edge_raddr = link_r;
        if (tgt_ok_r && (node_rsp.deg != '0)) begin
          node_req.deg_we    = 1'b1;
          node_req.deg_waddr = tgt_r;
          node_req.deg_wdata = node_rsp.deg - DEG_W'(1);
          if ((node_rsp.deg == DEG_W'(1)) && fifo_room) begin
            fifo_we    = 1'b1;
            fifo_wdata = tgt_r;
          end
        end
      end
      ST_FINISH: begin
        final_to_out = out_free;
        clear_all    = out_free;
      end
      default: ;
    endcase
    node_req.clear = clear_all;
  end

  // edge and queue memories
  always_ff @(posedge clk) begin
    if (tgt_we) begin
      edge_tgt_mem[new_edge] <= ld_dst_r;
    end
    if (link_we) begin
      edge_link_mem[link_waddr] <= new_edge;
    end
    if (fifo_we) begin
      fifo_mem[wptr_r[NODE_W-1:0]] <= fifo_wdata;
    end
    edge_tgt_q_r  <= edge_tgt_mem[edge_raddr];
    edge_link_q_r <= edge_link_mem[edge_raddr];
    fifo_q_r      <= fifo_mem[rptr_r[NODE_W-1:0]];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      node_count_r   <= NODES_MAX;
      edge_total_r   <= '0;
      rptr_r         <= '0;
      wptr_r         <= '0;
      emitted_r      <= '0;
      dropped_r      <= 1'b0;
      seed_idx_r     <= '0;
      seed_chk_vld_r <= 1'b0;
      pend_vld_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        node_count_r <= cfg_wr_data;
      end
      if (fifo_we) begin
        wptr_r <= wptr_r + CNT_W'(1);
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_mode == MODE_RUN) begin
              seed_idx_r     <= '0;
              seed_chk_vld_r <= 1'b0;
              emitted_r      <= '0;
              pend_vld_r     <= 1'b0;
            end else if (ld_drop) begin
              dropped_r <= 1'b1;
            end
          end
        end
        ST_LOAD_WR: edge_total_r <= edge_total_r + ETOT_W'(1);
        ST_SEED: begin
          seed_chk_vld_r <= seed_issue;
          if (seed_issue) begin
            seed_idx_r <= seed_idx_r + CNT_W'(1);
          end
        end
        ST_POP: begin
          if (pop_more && pop_go) begin
            rptr_r <= rptr_r + CNT_W'(1);
          end
        end
        ST_POP_WAIT: begin
          emitted_r  <= emitted_r + CNT_W'(1);
          pend_vld_r <= 1'b1;
        end
        ST_FINISH: begin
          if (out_free) begin
            edge_total_r <= '0;
            rptr_r       <= '0;
            wptr_r       <= '0;
            emitted_r    <= '0;
            dropped_r    <= 1'b0;
            pend_vld_r   <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // walk payload registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          ld_src_r <= in_edge_from;
          ld_dst_r <= in_edge_to;
        end
      end
      ST_SEED:      seed_chk_idx_r <= seed_idx_r[NODE_W-1:0];
      ST_POP_WAIT:  pend_node_r    <= fifo_q_r;
      ST_LIST_WAIT: begin
        edge_ptr_r <= node_rsp.list_head;
        tail_r     <= node_rsp.list_tail;
      end
      ST_EDGE_WAIT: begin
        tgt_r    <= edge_tgt_q_r;
        link_r   <= edge_link_q_r;
        last_r   <= (edge_ptr_r == tail_r);
        tgt_ok_r <= (CNT_W'(edge_tgt_q_r) < n_eff);
      end
      ST_DEG_WAIT:  edge_ptr_r <= link_r;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pend_to_out || final_to_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_to_out) begin
      out_node_r          <= pend_node_r;
      out_node_valid_r    <= 1'b1;
      out_last_r          <= 1'b0;
      out_cycle_found_r   <= 1'b0;
      out_edges_dropped_r <= 1'b0;
    end else if (final_to_out) begin
      out_node_r          <= pend_vld_r ? pend_node_r : '0;
      out_node_valid_r    <= pend_vld_r;
      out_last_r          <= 1'b1;
      out_cycle_found_r   <= (emitted_r < n_eff);
      out_edges_dropped_r <= dropped_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_node          = out_node_r;
  assign out_node_valid    = out_node_valid_r;
  assign out_last          = out_last_r;
  assign out_cycle_found   = out_cycle_found_r;
  assign out_edges_dropped = out_edges_dropped_r;

  // queue read pointer never passes the write pointer
  a_fifo_order: assert property (@(posedge clk) disable iff (!rst_n)
    rptr_r <= wptr_r)
    else $error("ready queue read pointer passed write pointer");

  // every popped node is counted as emitted in the cycle after the pop
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_POP_WAIT) |-> (rptr_r == emitted_r))
    else $error("pop count and emitted count disagree");

  // an edge write never runs past the edge store
  a_edge_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD_WR) |-> (edge_total_r < EDGES_MAX))
    else $error("edge written beyond store capacity");

  // finishing a run leaves the last result in the output register
  a_final_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && out_free) |=> (out_valid_r && out_last_r))
    else $error("final transaction not presented");

endmodule
